/* rtl/psd_pkg.sv */
// Package for the point-to-segment distance unit: widths, part codes and the
// request structs passed between pipeline sections. No dependencies.
package psd_pkg;

   localparam int COORD_WIDTH   = 16;
   localparam int FRACTION_BITS = 8;
   localparam int DIST_W        = 25;

   localparam int MAG_W  = COORD_WIDTH;
   localparam int LEN_W  = 2 * COORD_WIDTH + 1;
   localparam int QUOT_W = COORD_WIDTH + FRACTION_BITS;
   localparam int NUM_W  = COORD_WIDTH + LEN_W + FRACTION_BITS;
   localparam int ERR_W  = COORD_WIDTH + FRACTION_BITS + 1;
   localparam int D2_W   = 2 * ERR_W + 1;
   localparam int ROOT_W = (D2_W + 1) / 2;
   localparam int RAD_W  = 2 * ROOT_W;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic [MAG_W-1:0]  mag_type;
   typedef logic [LEN_W-1:0]  len_type;
   typedef logic [QUOT_W-1:0] quot_type;
   typedef logic [NUM_W-1:0]  num_type;
   typedef logic [D2_W-1:0]   d2_type;

   typedef enum logic [1:0] {
      PART_START = 2'd0,
      PART_END   = 2'd1,
      PART_INNER = 2'd2
   } part_type;

   typedef struct packed {
      part_type part;
      logic     ndx;
      logic     ndy;
      logic     npx;
      logic     npy;
      mag_type  apx;
      mag_type  apy;
      d2_type   d2end;
   } div_side_type;

   typedef struct packed {
      div_side_type side;
      num_type      numx;
      num_type      numy;
      len_type      len2;
   } div_in_type;

   typedef struct packed {
      div_side_type side;
      quot_type     qx;
      quot_type     qy;
   } div_out_type;

   typedef struct packed {
      part_type part;
      d2_type   d2;
   } root_in_type;

endpackage

/* rtl/psd_front.sv */
// Front section: coordinate differences, products, sums, part select and
// divider numerators over five stages. Depends on psd_pkg.
module psd_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  psd_pkg::coord_type   px,
   input  psd_pkg::coord_type   py,
   input  psd_pkg::coord_type   ax,
   input  psd_pkg::coord_type   ay,
   input  psd_pkg::coord_type   bx,
   input  psd_pkg::coord_type   by,
   output logic                 out_valid,
   input  logic                 out_ready,
   output psd_pkg::div_in_type  out_data
);
   import psd_pkg::*;

   localparam int NS = 5;

   typedef struct packed {
      logic    neg;
      mag_type mag;
   } sd_type;

   typedef struct packed {
      sd_type d_x, d_y, ap_x, ap_y, bp_x, bp_y;
   } s1_type;

   typedef struct packed {
      logic    ndx, ndy, npx, npy, sx, sy;
      mag_type dx, dy, apx, apy;
      logic [2*MAG_W-1:0] pxa, pya, lxx, lyy, aax, aay, bbx, bby;
   } s2_type;

   typedef struct packed {
      logic    ndx, ndy, npx, npy;
      mag_type dx, dy, apx, apy;
      len_type pos, neg, len2;
      d2_type  d2a, d2b;
   } s3_type;

   typedef struct packed {
      logic    ndx, ndy, npx, npy, start_sel;
      mag_type dx, dy, apx, apy;
      len_type dot, len2;
      d2_type  d2a, d2b;
   } s4_type;

   function automatic sd_type sdiff(coord_type a, coord_type b);
      logic [COORD_WIDTH:0] d;
      sd_type r;
      d = {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
      r.neg = d[COORD_WIDTH];
      r.mag = r.neg ? MAG_W'(-d) : MAG_W'(d);
      return r;
   endfunction

   function automatic logic [2*MAG_W-1:0] mul(mag_type a, mag_type b);
      return (2*MAG_W)'(a) * (2*MAG_W)'(b);
   endfunction

   logic [NS-1:0] v_ff, en;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   s4_type s4_ff, s4_in;
   div_in_type s5_ff, s5_in;
   logic [MAG_W+LEN_W-1:0] prodx, prody;

   always_comb begin
      en[NS-1] = !v_ff[NS-1] || out_ready;
      for (int i = NS - 2; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[NS-1];
   assign out_data  = s5_ff;

   always_comb begin
      s1_in.d_x  = sdiff(bx, ax);
      s1_in.d_y  = sdiff(by, ay);
      s1_in.ap_x = sdiff(px, ax);
      s1_in.ap_y = sdiff(py, ay);
      s1_in.bp_x = sdiff(px, bx);
      s1_in.bp_y = sdiff(py, by);
   end

   always_comb begin
      s2_in.ndx = s1_ff.d_x.neg;
      s2_in.ndy = s1_ff.d_y.neg;
      s2_in.npx = s1_ff.ap_x.neg;
      s2_in.npy = s1_ff.ap_y.neg;
      s2_in.sx  = s1_ff.d_x.neg != s1_ff.ap_x.neg;
      s2_in.sy  = s1_ff.d_y.neg != s1_ff.ap_y.neg;
      s2_in.dx  = s1_ff.d_x.mag;
      s2_in.dy  = s1_ff.d_y.mag;
      s2_in.apx = s1_ff.ap_x.mag;
      s2_in.apy = s1_ff.ap_y.mag;
      s2_in.pxa = mul(s1_ff.d_x.mag, s1_ff.ap_x.mag);
      s2_in.pya = mul(s1_ff.d_y.mag, s1_ff.ap_y.mag);
      s2_in.lxx = mul(s1_ff.d_x.mag, s1_ff.d_x.mag);
      s2_in.lyy = mul(s1_ff.d_y.mag, s1_ff.d_y.mag);
      s2_in.aax = mul(s1_ff.ap_x.mag, s1_ff.ap_x.mag);
      s2_in.aay = mul(s1_ff.ap_y.mag, s1_ff.ap_y.mag);
      s2_in.bbx = mul(s1_ff.bp_x.mag, s1_ff.bp_x.mag);
      s2_in.bby = mul(s1_ff.bp_y.mag, s1_ff.bp_y.mag);
   end

   always_comb begin
      s3_in.ndx  = s2_ff.ndx;
      s3_in.ndy  = s2_ff.ndy;
      s3_in.npx  = s2_ff.npx;
      s3_in.npy  = s2_ff.npy;
      s3_in.dx   = s2_ff.dx;
      s3_in.dy   = s2_ff.dy;
      s3_in.apx  = s2_ff.apx;
      s3_in.apy  = s2_ff.apy;
      s3_in.pos  = (s2_ff.sx ? '0 : LEN_W'(s2_ff.pxa)) + (s2_ff.sy ? '0 : LEN_W'(s2_ff.pya));
      s3_in.neg  = (s2_ff.sx ? LEN_W'(s2_ff.pxa) : '0) + (s2_ff.sy ? LEN_W'(s2_ff.pya) : '0);
      s3_in.len2 = LEN_W'(s2_ff.lxx) + LEN_W'(s2_ff.lyy);
      s3_in.d2a  = (D2_W'(s2_ff.aax) + D2_W'(s2_ff.aay)) << (2 * FRACTION_BITS);
      s3_in.d2b  = (D2_W'(s2_ff.bbx) + D2_W'(s2_ff.bby)) << (2 * FRACTION_BITS);
   end

   always_comb begin
      s4_in.ndx       = s3_ff.ndx;
      s4_in.ndy       = s3_ff.ndy;
      s4_in.npx       = s3_ff.npx;
      s4_in.npy       = s3_ff.npy;
      s4_in.dx        = s3_ff.dx;
      s4_in.dy        = s3_ff.dy;
      s4_in.apx       = s3_ff.apx;
      s4_in.apy       = s3_ff.apy;
      s4_in.start_sel = (s3_ff.pos <= s3_ff.neg) || (s3_ff.len2 == '0);
      s4_in.dot       = s3_ff.pos - s3_ff.neg;
      s4_in.len2      = s3_ff.len2;
      s4_in.d2a       = s3_ff.d2a;
      s4_in.d2b       = s3_ff.d2b;
   end

   always_comb begin
      prodx = (MAG_W+LEN_W)'(s4_ff.dx) * (MAG_W+LEN_W)'(s4_ff.dot);
      prody = (MAG_W+LEN_W)'(s4_ff.dy) * (MAG_W+LEN_W)'(s4_ff.dot);
      if (s4_ff.start_sel) begin
         s5_in.side.part  = PART_START;
         s5_in.side.d2end = s4_ff.d2a;
      end else if (s4_ff.dot >= s4_ff.len2) begin
         s5_in.side.part  = PART_END;
         s5_in.side.d2end = s4_ff.d2b;
      end else begin
         s5_in.side.part  = PART_INNER;
         s5_in.side.d2end = s4_ff.d2b;
      end
      s5_in.side.ndx = s4_ff.ndx;
      s5_in.side.ndy = s4_ff.ndy;
      s5_in.side.npx = s4_ff.npx;
      s5_in.side.npy = s4_ff.npy;
      s5_in.side.apx = s4_ff.apx;
      s5_in.side.apy = s4_ff.apy;
      s5_in.numx     = NUM_W'(prodx) << FRACTION_BITS;
      s5_in.numy     = NUM_W'(prody) << FRACTION_BITS;
      s5_in.len2     = s4_ff.len2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= (en & {v_ff[NS-2:0], in_valid}) | (~en & v_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) s1_ff <= s1_in;
      if (en[1]) s2_ff <= s2_in;
      if (en[2]) s3_ff <= s3_in;
      if (en[3]) s4_ff <= s4_in;
      if (en[4]) s5_ff <= s5_in;
   end

endmodule

/* rtl/psd_div.sv */
// Pipelined restoring divider, both axes side by side, one quotient bit per
// stage; carries the side payload along. Depends on psd_pkg.
module psd_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  psd_pkg::div_in_type   in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output psd_pkg::div_out_type  out_data
);
   import psd_pkg::*;

   localparam int NS = QUOT_W;

   typedef struct packed {
      len_type  rem;
      quot_type nq;
   } dv_type;

   typedef struct packed {
      div_side_type side;
      len_type      len2;
      dv_type       x;
      dv_type       y;
   } stage_type;

   function automatic dv_type step(dv_type s, len_type d);
      logic [LEN_W:0] t;
      logic           bit_q;
      dv_type         r;
      t     = {s.rem, s.nq[QUOT_W-1]};
      bit_q = t >= {1'b0, d};
      r.rem = bit_q ? LEN_W'(t - {1'b0, d}) : LEN_W'(t);
      r.nq  = {s.nq[QUOT_W-2:0], bit_q};
      return r;
   endfunction

   logic [NS-1:0] v_ff, en;
   stage_type stg_ff [NS];
   stage_type stg_in [NS];
   stage_type src;

   always_comb begin
      en[NS-1] = !v_ff[NS-1] || out_ready;
      for (int i = NS - 2; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[NS-1];

   always_comb begin
      for (int i = 0; i < NS; i++) begin
         if (i == 0) begin
            src.side   = in_data.side;
            src.len2   = in_data.len2;
            src.x.rem  = in_data.numx[NUM_W-1:QUOT_W];
            src.x.nq   = in_data.numx[QUOT_W-1:0];
            src.y.rem  = in_data.numy[NUM_W-1:QUOT_W];
            src.y.nq   = in_data.numy[QUOT_W-1:0];
         end else begin
            src = stg_ff[i-1];
         end
         stg_in[i].side = src.side;
         stg_in[i].len2 = src.len2;
         stg_in[i].x    = step(src.x, src.len2);
         stg_in[i].y    = step(src.y, src.len2);
      end
   end

   assign out_data.side = stg_ff[NS-1].side;
   assign out_data.qx   = stg_ff[NS-1].x.nq;
   assign out_data.qy   = stg_ff[NS-1].y.nq;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= (en & {v_ff[NS-2:0], in_valid}) | (~en & v_ff);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NS; i++) begin
         if (en[i]) stg_ff[i] <= stg_in[i];
      end
   end

endmodule

/* rtl/psd_resid.sv */
// Residual section: per-axis error of P against the interior point, squares
// and squared distance select over three stages. Depends on psd_pkg.
module psd_resid (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  psd_pkg::div_out_type  in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output psd_pkg::root_in_type  out_data
);
   import psd_pkg::*;

   localparam int NS = 3;

   typedef logic [ERR_W-1:0] err_type;

   typedef struct packed {
      part_type part;
      d2_type   d2end;
      err_type  ex, ey;
   } r1_type;

   typedef struct packed {
      part_type part;
      d2_type   d2end;
      logic [2*ERR_W-1:0] sqx, sqy;
   } r2_type;

   function automatic err_type abs_sub(logic nx, err_type mx, logic ny, err_type my);
      if (nx != ny) return mx + my;
      return (mx >= my) ? (mx - my) : (my - mx);
   endfunction

   logic [NS-1:0] v_ff, en;
   r1_type r1_ff, r1_in;
   r2_type r2_ff, r2_in;
   root_in_type r3_ff, r3_in;

   always_comb begin
      en[NS-1] = !v_ff[NS-1] || out_ready;
      for (int i = NS - 2; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[NS-1];
   assign out_data  = r3_ff;

   always_comb begin
      r1_in.part  = in_data.side.part;
      r1_in.d2end = in_data.side.d2end;
      r1_in.ex    = abs_sub(in_data.side.npx, ERR_W'(in_data.side.apx) << FRACTION_BITS,
                            in_data.side.ndx, ERR_W'(in_data.qx));
      r1_in.ey    = abs_sub(in_data.side.npy, ERR_W'(in_data.side.apy) << FRACTION_BITS,
                            in_data.side.ndy, ERR_W'(in_data.qy));
   end

   always_comb begin
      r2_in.part  = r1_ff.part;
      r2_in.d2end = r1_ff.d2end;
      r2_in.sqx   = (2*ERR_W)'(r1_ff.ex) * (2*ERR_W)'(r1_ff.ex);
      r2_in.sqy   = (2*ERR_W)'(r1_ff.ey) * (2*ERR_W)'(r1_ff.ey);
   end

   always_comb begin
      r3_in.part = r2_ff.part;
      if (r2_ff.part == PART_INNER) begin
         r3_in.d2 = D2_W'(r2_ff.sqx) + D2_W'(r2_ff.sqy);
      end else begin
         r3_in.d2 = r2_ff.d2end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= (en & {v_ff[NS-2:0], in_valid}) | (~en & v_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) r1_ff <= r1_in;
      if (en[1]) r2_ff <= r2_in;
      if (en[2]) r3_ff <= r3_in;
   end

endmodule

/* rtl/psd_sqrt.sv */
// Pipelined floor square root, one root bit per stage, carrying the part
// code; the last stage is the result register. Depends on psd_pkg.
module psd_sqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  psd_pkg::root_in_type  in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [psd_pkg::ROOT_W-1:0] out_root,
   output psd_pkg::part_type     out_part
);
   import psd_pkg::*;

   localparam int NS = ROOT_W;

   typedef struct packed {
      part_type            part;
      logic [RAD_W-1:0]    rad;
      logic [ROOT_W+1:0]   rem;
      logic [ROOT_W-1:0]   root;
   } stage_type;

   function automatic stage_type step(stage_type s);
      logic [ROOT_W+3:0] t, trial;
      logic              take;
      stage_type         r;
      t      = {s.rem, s.rad[RAD_W-1:RAD_W-2]};
      trial  = {(ROOT_W+2)'(s.root), 2'b01};
      take   = t >= trial;
      r.part = s.part;
      r.rad  = s.rad << 2;
      r.rem  = take ? (ROOT_W+2)'(t - trial) : (ROOT_W+2)'(t);
      r.root = {s.root[ROOT_W-2:0], take};
      return r;
   endfunction

   logic [NS-1:0] v_ff, en;
   stage_type stg_ff [NS];
   stage_type stg_in [NS];
   stage_type src;

   always_comb begin
      en[NS-1] = !v_ff[NS-1] || out_ready;
      for (int i = NS - 2; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[NS-1];
   assign out_root  = stg_ff[NS-1].root;
   assign out_part  = stg_ff[NS-1].part;

   always_comb begin
      for (int i = 0; i < NS; i++) begin
         if (i == 0) begin
            src.part = in_data.part;
            src.rad  = RAD_W'(in_data.d2);
            src.rem  = '0;
            src.root = '0;
         end else begin
            src = stg_ff[i-1];
         end
         stg_in[i] = step(src);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= (en & {v_ff[NS-2:0], in_valid}) | (~en & v_ff);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NS; i++) begin
         if (en[i]) stg_ff[i] <= stg_in[i];
      end
   end

endmodule

/* rtl/point_segment_distance_unit.sv */
// Point-to-segment distance unit: front, divider, residual and square root.
// Throughput one request per cycle while responses are taken; each stage holds while its successor is full and stalled.
// Synchronous active-high reset clears all valid bits; no clearing pass.
// Depends on psd_pkg, psd_front, psd_div, psd_resid and psd_sqrt.
module point_segment_distance_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [psd_pkg::COORD_WIDTH-1:0] req_point_x,
   input  logic signed [psd_pkg::COORD_WIDTH-1:0] req_point_y,
   input  logic signed [psd_pkg::COORD_WIDTH-1:0] req_start_x,
   input  logic signed [psd_pkg::COORD_WIDTH-1:0] req_start_y,
   input  logic signed [psd_pkg::COORD_WIDTH-1:0] req_end_x,
   input  logic signed [psd_pkg::COORD_WIDTH-1:0] req_end_y,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [psd_pkg::DIST_W-1:0]         rsp_distance,
   output logic [1:0]                         rsp_nearest_part
);
   import psd_pkg::*;

   logic        f_valid, f_ready, d_valid, d_ready, r_valid, r_ready;
   div_in_type  f_data;
   div_out_type d_data;
   root_in_type r_data;
   logic [ROOT_W-1:0] root;
   part_type    part;

   psd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .px        (req_point_x),
      .py        (req_point_y),
      .ax        (req_start_x),
      .ay        (req_start_y),
      .bx        (req_end_x),
      .by        (req_end_y),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_data  (f_data)
   );

   psd_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (f_data),
      .out_valid (d_valid),
      .out_ready (d_ready),
      .out_data  (d_data)
   );

   psd_resid u_resid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_valid),
      .in_ready  (d_ready),
      .in_data   (d_data),
      .out_valid (r_valid),
      .out_ready (r_ready),
      .out_data  (r_data)
   );

   psd_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (r_valid),
      .in_ready  (r_ready),
      .in_data   (r_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_root  (root),
      .out_part  (part)
   );

   assign rsp_distance     = DIST_W'(root);
   assign rsp_nearest_part = part;

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_ready || !rsp_valid) |-> req_ready)
      else $error("request stalled while the pipeline can advance");

   a_part_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_nearest_part != 2'd3))
      else $error("illegal nearest part code");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_inner_stage: assert property (@(posedge clock) disable iff (reset)
      (d_valid && d_data.side.part == PART_INNER) |-> (d_data.qx[0] == d_data.qx[0]))
      else $error("interior quotient undefined");

endmodule

/* dv/testbench.sv */
// Self-checking bench for point_segment_distance_unit: directed table, then random requests,
// every response checked against an in-bench distance predictor. Depends on psd_pkg.
`timescale 1ns / 1ps

module testbench;
   import psd_pkg::*;

   localparam int FB = FRACTION_BITS;
   localparam int N_RANDOM = 1550;
   localparam int SETTLE = 80;

   typedef struct {
      logic [15:0] px, py, ax, ay, bx, by;
      logic        has_exp;
      logic [24:0] exp_dist;
      logic [1:0]  exp_part;
   } query_row_type;

   typedef struct {
      logic [24:0] dist_val;
      logic [1:0]  part;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [15:0] req_point_x = '0, req_point_y = '0, req_start_x = '0;
   logic signed [15:0] req_start_y = '0, req_end_x = '0, req_end_y = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [24:0] rsp_distance;
   logic [1:0]  rsp_nearest_part;

   answer_type pending_answers[$];
   int error_count = 0;
   bit stim_done = 1'b0;

   point_segment_distance_unit dut (.*);

   always #1 clock = ~clock;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d want %0d", what, got, want);
      error_count++;
   endtask

   function automatic void diff_sm(input logic [15:0] a, input logic [15:0] b,
                                   output bit neg, output longint unsigned mag);
      longint signed d;
      d = longint'($signed(a)) - longint'($signed(b));
      neg = d < 0;
      mag = neg ? -d : d;
   endfunction

   function automatic longint unsigned floor_sqrt(input longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint unsigned mag_sub(input bit nx, input longint unsigned mx,
                                               input bit ny, input longint unsigned my);
      if (nx != ny) return mx + my;
      return (mx >= my) ? mx - my : my - mx;
   endfunction

   function automatic answer_type predict_distance(input query_row_type q);
      answer_type r;
      bit ndx, ndy, npx, npy, nbx, nby;
      longint unsigned dx, dy, apx, apy, bpx, bpy, pos, negs, len2, dot, d2, ox, oy, ex, ey;
      diff_sm(q.bx, q.ax, ndx, dx);
      diff_sm(q.by, q.ay, ndy, dy);
      diff_sm(q.px, q.ax, npx, apx);
      diff_sm(q.py, q.ay, npy, apy);
      diff_sm(q.px, q.bx, nbx, bpx);
      diff_sm(q.py, q.by, nby, bpy);
      pos = 0;
      negs = 0;
      if (ndx != npx) negs += dx * apx; else pos += dx * apx;
      if (ndy != npy) negs += dy * apy; else pos += dy * apy;
      len2 = dx * dx + dy * dy;
      if (pos <= negs || len2 == 0) begin
         r.part = PART_START;
         d2 = (apx * apx + apy * apy) << (2 * FB);
      end else begin
         dot = pos - negs;
         if (dot >= len2) begin
            r.part = PART_END;
            d2 = (bpx * bpx + bpy * bpy) << (2 * FB);
         end else begin
            ox = ((dx * dot) << FB) / len2;
            oy = ((dy * dot) << FB) / len2;
            ex = mag_sub(npx, apx << FB, ndx, ox);
            ey = mag_sub(npy, apy << FB, ndy, oy);
            r.part = PART_INNER;
            d2 = ex * ex + ey * ey;
         end
      end
      r.dist_val = 25'(floor_sqrt(d2));
      return r;
   endfunction

   function automatic query_row_type mk(input int px, py, ax, ay, bx, by,
                                        input bit he = 0, input int ed = 0, input int ep = 0);
      query_row_type q;
      q.px = 16'(px); q.py = 16'(py); q.ax = 16'(ax); q.ay = 16'(ay);
      q.bx = 16'(bx); q.by = 16'(by);
      q.has_exp = he; q.exp_dist = 25'(ed); q.exp_part = 2'(ep);
      return q;
   endfunction

   function automatic logic [15:0] rand_coord(input int span);
      if (span == 0) return 16'($urandom);
      return 16'($signed($urandom_range(0, 2 * span)) - span);
   endfunction

   function automatic int short_gap();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
   endfunction

   task automatic send_query(input query_row_type q);
      answer_type a;
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? short_gap() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      a = predict_distance(q);
      if (q.has_exp && (a.dist_val !== q.exp_dist || a.part !== q.exp_part))
         report_mismatch("table row vs predictor", a.dist_val, q.exp_dist);
      pending_answers.push_back(a);
      req_valid <= 1'b1;
      req_point_x <= q.px; req_point_y <= q.py;
      req_start_x <= q.ax; req_start_y <= q.ay;
      req_end_x <= q.bx; req_end_y <= q.by;
      do @(posedge clock); while (!req_ready);
   endtask

   always @(posedge clock) begin
      answer_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_answers.size() == 0) begin
            report_mismatch("unexpected response", rsp_distance, 0);
         end else begin
            w = pending_answers.pop_front();
            if (rsp_distance !== w.dist_val)
               report_mismatch("distance", rsp_distance, w.dist_val);
            if (rsp_nearest_part !== w.part)
               report_mismatch("nearest_part", rsp_nearest_part, w.part);
         end
      end
   end

   initial begin
      int g;
      @(posedge clock);
      while (!stim_done || pending_answers.size() != 0) begin
         g = ($urandom_range(0, 2) == 0) ? short_gap() : 0;
         rsp_ready <= (g == 0);
         @(posedge clock);
         if (g != 0) begin
            repeat (g - 1) @(posedge clock);
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
      rsp_ready <= 1'b1;
   end

   initial begin
      query_row_type rows[$];
      query_row_type q;
      int span;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      rows.push_back(mk(0, 0, 0, 0, 0, 0, 1, 0, PART_START));
      rows.push_back(mk(3, 4, 0, 0, 0, 0, 1, 5 << 8, PART_START));
      rows.push_back(mk(-3, 0, 0, 0, 10, 0, 1, 3 << 8, PART_START));
      rows.push_back(mk(13, 4, 0, 0, 10, 0, 1, 5 << 8, PART_END));
      rows.push_back(mk(10, 7, 0, 0, 10, 0, 1, 7 << 8, PART_END));
      rows.push_back(mk(5, 2, 0, 0, 10, 0, 1, 2 << 8, PART_INNER));
      rows.push_back(mk(-2, 5, 0, 0, 0, 10, 1, 2 << 8, PART_INNER));
      rows.push_back(mk(32767, 32767, -32768, -32768, -32768, -32768));
      rows.push_back(mk(-32768, -32768, 32767, 32767, 32767, 32767));
      rows.push_back(mk(-32768, 32767, -32768, -32768, 32767, 32767));
      rows.push_back(mk(32767, -32768, -32768, -32768, 32767, 32767));
      rows.push_back(mk(0, 0, -32768, -32768, 32767, 32767));
      rows.push_back(mk(1, 0, 0, 0, 3, 1));
      rows.push_back(mk(-1, -1, 2, 3, -7, 5));
      rows.push_back(mk(32767, 0, -32768, 0, 32767, 1));
      rows.push_back(mk(-32768, -32768, -32768, -32768, -32768, 32767));
      rows.push_back(mk(100, 100, 0, 0, 0, 0));
      rows.push_back(mk(-21845, 21845, 21845, -21845, -1, 1));
      foreach (rows[i]) send_query(rows[i]);
      for (int n = 0; n < N_RANDOM; n++) begin
         if (n == N_RANDOM / 2) begin
            req_valid <= 1'b0;
            wait (pending_answers.size() == 0);
            @(posedge clock);
         end
         case ($urandom_range(0, 3))
            0: span = 0;
            1: span = 20;
            2: span = 1000;
            default: span = 32767;
         endcase
         q = mk(0, 0, 0, 0, 0, 0);
         q.px = rand_coord(span); q.py = rand_coord(span);
         q.ax = rand_coord(span); q.ay = rand_coord(span);
         q.bx = rand_coord(span); q.by = rand_coord(span);
         if ($urandom_range(0, 19) == 0) begin
            q.bx = q.ax; q.by = q.ay;
         end
         send_query(q);
      end
      req_valid <= 1'b0;
      stim_done = 1'b1;
      wait (pending_answers.size() == 0);
      repeat (SETTLE) @(posedge clock);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
